// ===== rtl/core/kfms_pkg.sv =====
// ============================================================================
// kfms_pkg: shared types and constants for the KMP first-match search
// Payload structs, configuration register indexes, sizing constants.
// ============================================================================
`default_nettype none

package kfms_pkg;

    localparam int MAX_PATTERN_LEN = 16;
    localparam int TEXT_INDEX_BITS = 16;

    // pattern length field width, border row index width
    localparam int LEN_W = $clog2(MAX_PATTERN_LEN + 1);
    localparam int ROW_W = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;

    // one border cell per pattern byte that can be compared during the build
    localparam int NUM_CELLS = MAX_PATTERN_LEN - 1;

    localparam int REG_W     = 64;
    localparam int PATTERN_W = 2 * REG_W;
    localparam int POS_W     = 16;
    localparam int START_W   = 16;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LEN  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEARCH_START = 2'd3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       first_byte;
        logic       last_byte;
    } text_item_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] match_position;
        logic             index_overflow;
    } result_item_t;

    typedef struct packed {
        logic             busy;
        logic [ROW_W-1:0] row;
    } build_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/kfms_cell.sv =====
// ============================================================================
// kfms_cell: one cell of the border chain
// Holds one pattern byte and one border bit; the bit moves one cell to the
// right per build step when the held byte equals the broadcast byte.
// ============================================================================
`default_nettype none

module kfms_cell (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       step,
    input  logic [7:0] load_byte,
    input  logic [7:0] bcast_byte,
    input  logic       left_border,
    output logic       border,
    output logic [7:0] held_byte
);

    logic       border_reg;
    logic       border_next;
    logic [7:0] byte_reg;

    always_comb
    begin
        border_next = border_reg;
        if (start)
        begin
            border_next = 1'b0;
        end
        else if (step)
        begin
            border_next = left_border && (byte_reg == bcast_byte);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            border_reg <= 1'b0;
        end
        else
        begin
            border_reg <= border_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            byte_reg <= load_byte;
        end
    end

    assign border    = border_reg;
    assign held_byte = byte_reg;

endmodule

`default_nettype wire

// ===== rtl/core/kfms_builder.sv =====
// ============================================================================
// kfms_builder: border row builder and row store
// A chain of cells produces, one row per cycle, the set of border lengths of
// each pattern prefix. Row j lists j and every length the failure walk from
// j visits. Rows are kept in a small register store read at one index.
// ============================================================================
`default_nettype none

module kfms_builder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [kfms_pkg::PATTERN_W-1:0]      pattern,
    input  logic [kfms_pkg::ROW_W-1:0]          rd_index,
    output logic [kfms_pkg::MAX_PATTERN_LEN-1:0] rd_row,
    output kfms_pkg::build_status_t             status
);

    localparam logic [kfms_pkg::ROW_W-1:0] LAST_ROW =
        kfms_pkg::ROW_W'(kfms_pkg::MAX_PATTERN_LEN - 1);

    logic                                busy_reg;
    logic                                busy_next;
    logic [kfms_pkg::ROW_W-1:0]          row_reg;
    logic [kfms_pkg::ROW_W-1:0]          row_next;
    logic                                step;
    logic [7:0]                          bcast_byte;
    logic [kfms_pkg::NUM_CELLS-1:0]      cell_border;
    logic [kfms_pkg::NUM_CELLS-1:0]      cell_left;
    logic [7:0]                          cell_byte [kfms_pkg::NUM_CELLS];
    logic [kfms_pkg::MAX_PATTERN_LEN-1:0] row_mem [kfms_pkg::MAX_PATTERN_LEN];

    // row r+1 compares every held byte against pattern byte r
    assign step       = busy_reg && (row_reg != LAST_ROW);
    assign bcast_byte = (row_reg != LAST_ROW) ? cell_byte[row_reg] : 8'h00;

    for (genvar k = 0; k < kfms_pkg::NUM_CELLS; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            assign cell_left[k] = 1'b1;
        end
        else
        begin : g_body
            assign cell_left[k] = cell_border[k-1];
        end

        kfms_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .start       (start),
            .step        (step),
            .load_byte   (pattern[8*k +: 8]),
            .bcast_byte  (bcast_byte),
            .left_border (cell_left[k]),
            .border      (cell_border[k]),
            .held_byte   (cell_byte[k])
        );
    end

    always_comb
    begin
        busy_next = busy_reg;
        row_next  = row_reg;
        if (start)
        begin
            busy_next = 1'b1;
            row_next  = '0;
        end
        else if (busy_reg)
        begin
            if (row_reg == LAST_ROW)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                row_next = row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            row_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            row_reg  <= row_next;
        end
    end

    // empty border is always present
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            row_mem[row_reg] <= {cell_border, 1'b1};
        end
    end

    // row 0 is fixed, so the first byte of a text needs no built row
    assign rd_row = (rd_index == '0) ? kfms_pkg::MAX_PATTERN_LEN'(1) : row_mem[rd_index];

    assign status.busy = busy_reg;
    assign status.row  = row_reg;

endmodule

`default_nettype wire

// ===== rtl/core/kmp_first_match_search.sv =====
// ============================================================================
// kmp_first_match_search: streaming first-match pattern search
// Knuth-Morris-Pratt search of a 1..16 byte pattern over a byte stream.
// ============================================================================
// One text byte is taken per cycle when text_stall is low. A first byte
// starts a build in the border cell chain (one prefix row per cycle); while
// it runs, a byte whose partial match has reached a row not yet built waits,
// which happens only right after a first byte. Each byte's whole failure
// walk is settled combinationally from its border row. The single result of
// a text appears on the result channel in the cycle after the byte that
// decides it, and the next byte is taken while that result waits, unless
// the result register is still held by a stall. No clearing pass.
`default_nettype none

module kmp_first_match_search (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [kfms_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [kfms_pkg::REG_W-1:0]        cfg_data,
    input  logic                              text_valid,
    output logic                              text_stall,
    input  kfms_pkg::text_item_t              text_item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output kfms_pkg::result_item_t            result_item
);

    localparam int IDX_EXT_W = kfms_pkg::TEXT_INDEX_BITS + 1;

    logic [kfms_pkg::REG_W-1:0]           pattern_low_reg;
    logic [kfms_pkg::REG_W-1:0]           pattern_high_reg;
    logic [kfms_pkg::LEN_W-1:0]           pattern_length_reg;
    logic [kfms_pkg::START_W-1:0]         search_start_reg;

    logic [kfms_pkg::LEN_W-1:0]           matched_reg;
    logic [kfms_pkg::LEN_W-1:0]           matched_next;
    logic [kfms_pkg::TEXT_INDEX_BITS-1:0] index_reg;
    logic [kfms_pkg::TEXT_INDEX_BITS-1:0] index_next;
    logic                                 done_reg;
    logic                                 done_next;
    logic                                 overflow_reg;
    logic                                 overflow_next;
    logic                                 result_valid_reg;
    logic                                 result_valid_next;
    kfms_pkg::result_item_t               result_reg;
    kfms_pkg::result_item_t               result_next;

    logic [kfms_pkg::PATTERN_W-1:0]       pattern;
    logic [kfms_pkg::LEN_W-1:0]           len_use;
    logic                                 accept;
    logic                                 active;
    logic                                 build_wait;
    logic                                 out_blocked;

    logic [kfms_pkg::TEXT_INDEX_BITS-1:0] idx_cur;
    logic                                 ovf_cur;
    logic [kfms_pkg::LEN_W-1:0]           matched_base;
    logic [kfms_pkg::ROW_W-1:0]           walk_start;
    logic [kfms_pkg::MAX_PATTERN_LEN-1:0] walk_row;
    logic [kfms_pkg::MAX_PATTERN_LEN-1:0] byte_eq;
    logic [kfms_pkg::MAX_PATTERN_LEN-1:0] hits;
    logic [kfms_pkg::LEN_W-1:0]           matched_new;
    logic                                 in_range;
    logic                                 hit;
    logic [IDX_EXT_W-1:0]                 pos_sum;

    kfms_pkg::build_status_t              status;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= kfms_pkg::LEN_W'(1);
            search_start_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                kfms_pkg::CFG_PATTERN_LOW:  pattern_low_reg    <= cfg_data;
                kfms_pkg::CFG_PATTERN_HIGH: pattern_high_reg   <= cfg_data;
                kfms_pkg::CFG_PATTERN_LEN:  pattern_length_reg <= cfg_data[kfms_pkg::LEN_W-1:0];
                kfms_pkg::CFG_SEARCH_START: search_start_reg   <= cfg_data[kfms_pkg::START_W-1:0];
            endcase
        end
    end

    assign pattern = {pattern_high_reg, pattern_low_reg};

    always_comb
    begin
        if (pattern_length_reg == '0)
        begin
            len_use = kfms_pkg::LEN_W'(1);
        end
        else if (pattern_length_reg > kfms_pkg::LEN_W'(kfms_pkg::MAX_PATTERN_LEN))
        begin
            len_use = kfms_pkg::LEN_W'(kfms_pkg::MAX_PATTERN_LEN);
        end
        else
        begin
            len_use = pattern_length_reg;
        end
    end

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    assign out_blocked = result_valid_reg && result_stall;
    // rows below status.row are stored; the walk never starts above matched_reg
    assign build_wait  = status.busy && !done_reg && (matched_reg != '0) &&
                         (matched_reg >= kfms_pkg::LEN_W'(status.row));
    assign text_stall  = out_blocked || build_wait;
    assign accept      = text_valid && !text_stall;
    assign active      = text_item.first_byte || !done_reg;

    kfms_builder u_builder (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && text_item.first_byte),
        .pattern  (pattern),
        .rd_index (walk_start),
        .rd_row   (walk_row),
        .status   (status)
    );

    // ------------------------------------------------------------------
    // per-byte match step
    // ------------------------------------------------------------------
    always_comb
    begin
        if (text_item.first_byte)
        begin
            idx_cur      = '0;
            ovf_cur      = 1'b0;
            matched_base = '0;
        end
        else
        begin
            matched_base = matched_reg;
            ovf_cur      = overflow_reg;
            idx_cur      = index_reg;
            if (index_reg == {kfms_pkg::TEXT_INDEX_BITS{1'b1}})
            begin
                ovf_cur = 1'b1;
            end
            else
            begin
                idx_cur = index_reg + 1'b1;
            end
        end
    end

    assign in_range   = 32'(idx_cur) >= 32'(search_start_reg);
    // a count left at or above a shortened length restarts at zero
    assign walk_start = (matched_base >= len_use) ? '0 : kfms_pkg::ROW_W'(matched_base);

    always_comb
    begin
        for (int k = 0; k < kfms_pkg::MAX_PATTERN_LEN; k++)
        begin
            byte_eq[k] = (pattern[8*k +: 8] == text_item.text_byte);
        end
    end

    // longest candidate on the failure path whose next byte matches
    assign hits = walk_row & byte_eq;

    always_comb
    begin
        matched_new = '0;
        for (int k = 0; k < kfms_pkg::MAX_PATTERN_LEN; k++)
        begin
            if (hits[k])
            begin
                matched_new = kfms_pkg::LEN_W'(k + 1);
            end
        end
    end

    assign hit     = in_range && (matched_new == len_use);
    assign pos_sum = IDX_EXT_W'(idx_cur) + IDX_EXT_W'(1) - IDX_EXT_W'(len_use);

    always_comb
    begin
        matched_next      = matched_reg;
        index_next        = index_reg;
        done_next         = done_reg;
        overflow_next     = overflow_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        if (accept && active)
        begin
            index_next    = idx_cur;
            overflow_next = ovf_cur;
            matched_next  = in_range ? matched_new : matched_base;
            done_next     = 1'b0;
            if (hit)
            begin
                done_next                  = 1'b1;
                result_valid_next          = 1'b1;
                result_next.found          = 1'b1;
                result_next.match_position = kfms_pkg::POS_W'(pos_sum);
                result_next.index_overflow = ovf_cur;
            end
            else if (text_item.last_byte)
            begin
                done_next                  = 1'b1;
                result_valid_next          = 1'b1;
                result_next.found          = 1'b0;
                result_next.match_position = '0;
                result_next.index_overflow = ovf_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matched_reg      <= '0;
            index_reg        <= '0;
            done_reg         <= 1'b1;
            overflow_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            matched_reg      <= matched_next;
            index_reg        <= index_next;
            done_reg         <= done_next;
            overflow_reg     <= overflow_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_reg;

`ifndef NO_ASSERTIONS
    a_result_from_request: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(text_valid && !text_stall))
        else $error("result appeared without an accepted request");

    a_build_on_first: assert property (@(posedge clk) disable iff (!rst_n)
        (text_valid && !text_stall && text_item.first_byte) |=>
            (status.busy && (status.row == '0)))
        else $error("first byte did not restart the border build");

    a_result_ends_search: assert property (@(posedge clk) disable iff (!rst_n)
        (text_valid && !text_stall && active && (hit || text_item.last_byte)) |=>
            (done_reg && result_valid))
        else $error("deciding byte did not close the search");

    a_matched_bound: assert property (@(posedge clk) disable iff (!rst_n)
        matched_reg <= kfms_pkg::LEN_W'(kfms_pkg::MAX_PATTERN_LEN))
        else $error("partial match count out of range");
`endif

endmodule

`default_nettype wire
